@@ rtl/dip_pkg.sv @@
package dip_pkg;

  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_SIGN_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LO_LIMIT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HI_LIMIT  = 2'd2;

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_SET   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;

  localparam logic signed [63:0] INT64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] INT64_MAX = {1'b0, {63{1'b1}}};

  typedef struct packed {
    logic [7:0] char_byte;
    logic       start_flag;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] value;
    logic [15:0]        consumed_length;
  } result_t;

endpackage

@@ rtl/decimal_integer_parser.sv @@
// item beats register into the stage register, result beats into the output register
// throughput: one item per cycle unless a result stalls; next-state path is a multiply
// by ten (shift-add), a digit add and an overflow check on a 68-bit sum, combinational
// a result beat waiting under stall holds items that would give a result; others pass
// rst (synchronous, active high) empties both registers, clears the parse to idle and
// loads sign_mode 0, lo_limit INT64_MIN, hi_limit INT64_MAX
module decimal_integer_parser
  import dip_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data
);

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_NEED_DIGIT = 2'd1,
    PH_DIGITS     = 2'd2
  } phase_t;

  logic [1:0]         sign_mode;
  logic signed [63:0] lo_limit;
  logic signed [63:0] hi_limit;

  phase_t             phase, phase_next;
  logic               neg, neg_next;
  logic signed [63:0] acc, acc_next;
  logic [15:0]        count, count_next;

  logic  stage_valid;
  item_t stage;

  logic        proc_fire;
  logic        emit;
  logic [1:0]  emit_status;
  logic [63:0] emit_value;
  logic [15:0] emit_len;

  phase_t             eff_phase;
  logic               eff_neg;
  logic signed [63:0] eff_acc;
  logic [15:0]        eff_count;
  logic               is_digit;
  logic               sign_char;
  logic [3:0]         digit;
  logic [67:0]        acc_wide;
  logic [67:0]        acc_times10;
  logic [67:0]        acc_sum;
  logic               overflow;
  logic [15:0]        count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      sign_mode <= 2'b00;
      lo_limit  <= INT64_MIN;
      hi_limit  <= INT64_MAX;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SIGN_MODE: sign_mode <= cfg_data[1:0];
        CFG_LO_LIMIT:  lo_limit  <= cfg_data;
        CFG_HI_LIMIT:  hi_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // datapath on the staged beat
  always_comb begin
    is_digit  = (stage.char_byte >= CHAR_ZERO) && (stage.char_byte <= CHAR_NINE);
    sign_char = stage.start_flag && (sign_mode == 2'b00) &&
                ((stage.char_byte == CHAR_MINUS) || (stage.char_byte == CHAR_PLUS));
    digit     = 4'(stage.char_byte - CHAR_ZERO);
    eff_phase = stage.start_flag ? PH_NEED_DIGIT : phase;
    eff_neg   = stage.start_flag ? sign_mode[1] : neg;
    eff_acc   = stage.start_flag ? 64'sd0 : acc;
    eff_count = stage.start_flag ? 16'd0 : count;

    acc_wide    = {{4{eff_acc[63]}}, eff_acc};
    acc_times10 = (acc_wide << 3) + (acc_wide << 1);
    acc_sum     = eff_neg ? acc_times10 - {64'd0, digit} : acc_times10 + {64'd0, digit};
    overflow    = !((acc_sum[67:63] == 5'b00000) || (acc_sum[67:63] == 5'b11111));
    count_inc   = (eff_count == 16'hffff) ? eff_count : eff_count + 16'd1;
  end

  always_comb begin
    phase_next  = phase;
    neg_next    = neg;
    acc_next    = acc;
    count_next  = count;
    emit        = 1'b0;
    emit_status = ST_NONE;
    emit_value  = 64'd0;
    emit_len    = 16'd0;
    if (sign_char) begin
      phase_next = PH_NEED_DIGIT;
      neg_next   = (stage.char_byte == CHAR_MINUS);
      acc_next   = 64'sd0;
      count_next = 16'd1;
    end else begin
      case (eff_phase)
        PH_NEED_DIGIT: begin
          neg_next   = eff_neg;
          acc_next   = eff_acc;
          count_next = eff_count;
          if (is_digit) begin
            acc_next   = acc_sum[63:0];
            count_next = count_inc;
            phase_next = PH_DIGITS;
          end else begin
            emit       = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            if (overflow) begin
              emit        = 1'b1;
              emit_status = ST_RANGE;
              phase_next  = PH_IDLE;
            end else begin
              acc_next   = acc_sum[63:0];
              count_next = count_inc;
            end
          end else begin
            emit       = 1'b1;
            phase_next = PH_IDLE;
            if ((acc < lo_limit) || (acc > hi_limit)) begin
              emit_status = ST_RANGE;
            end else begin
              emit_status = ST_SET;
              emit_value  = acc;
              emit_len    = count;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  assign proc_fire  = stage_valid && (!emit || !result_valid || !result_stall);
  assign item_stall = stage_valid && !proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid  <= 1'b0;
      result_valid <= 1'b0;
      phase        <= PH_IDLE;
      neg          <= 1'b0;
      acc          <= 64'sd0;
      count        <= 16'd0;
    end else begin
      if (!item_stall) begin
        stage_valid <= item_valid;
      end
      if (proc_fire) begin
        phase <= phase_next;
        neg   <= neg_next;
        acc   <= acc_next;
        count <= count_next;
      end
      if (proc_fire && emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage <= item;
    end
    if (proc_fire && emit) begin
      result.status          <= emit_status;
      result.value           <= emit_value;
      result.consumed_length <= emit_len;
    end
  end

  a_clear_unless_set: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != ST_SET) |->
      (result.value == 64'd0) && (result.consumed_length == 16'd0))
    else $error("value or length nonzero on a beat without a set status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (result.status == ST_NONE) || (result.status == ST_SET) || (result.status == ST_RANGE))
    else $error("undefined status code");

  a_acc_sign: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DIGITS) |-> (neg ? (acc <= 64'sd0) : (acc >= 64'sd0)))
    else $error("accumulator sign disagrees with the negative flag");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !proc_fire |=> stage_valid && $stable(stage))
    else $error("staged beat lost while held");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(proc_fire && emit))
    else $error("result beat without a finishing item");

endmodule
